// ----- rtl/core/ast_pkg.sv -----
// ast_pkg: shared types, constants and character codes for the tokenizer
// no dependencies; used by ast_front, ast_queue, ast_back and the top level

package ast_pkg;

    // position and literal widths
    localparam int POS_BITS = 16;
    localparam int VAL_BITS = 32;
    // headroom for acc * 16 + 15
    localparam int ACC_EXT_BITS = VAL_BITS + 5;

    // token records held between front and back
    localparam int TOK_SLOTS = 3;
    localparam int CNT_BITS = 2;
    localparam int SLOT_IDX_BITS = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // token kinds
    typedef enum logic [3:0] {
        TK_NEWLINE = 4'd0,
        TK_LPAREN  = 4'd1,
        TK_RPAREN  = 4'd2,
        TK_LSQUARE = 4'd3,
        TK_RSQUARE = 4'd4,
        TK_COMMA   = 4'd5,
        TK_IDENT   = 4'd6,
        TK_DECIMAL = 4'd7,
        TK_HEX     = 4'd8,
        TK_BINARY  = 4'd9,
        TK_COMMENT = 4'd10,
        TK_ERROR   = 4'd11,
        TK_END     = 4'd12
    } kind_t;

    // input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_final;
    } src_item_t;

    // result item
    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] token_value;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic        value_overflow;
        logic        last_of_run;
    } tok_item_t;

    // all tokens caused by one byte, packed from slot 0
    typedef struct packed {
        logic [CNT_BITS-1:0]               count;
        tok_item_t [TOK_SLOTS-1:0]         slot;
    } tok_rec_t;

    // queue status seen by the back end
    typedef struct packed {
        logic     empty;
        tok_rec_t head;
    } q_head_t;

    // whitespace test
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
            || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- rtl/core/ast_front.sv -----
// ast_front: scanner that takes one byte per item and builds its token record
// depends on ast_pkg; feeds ast_queue

module ast_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  ast_pkg::src_item_t  src_item,
    input  logic                q_full,
    output logic                q_push,
    output ast_pkg::tok_rec_t   q_rec
);

    typedef enum logic [7:0] {
        M_START   = 8'b0000_0001,
        M_IDENT   = 8'b0000_0010,
        M_PREFIX  = 8'b0000_0100,
        M_DEC     = 8'b0000_1000,
        M_HEX     = 8'b0001_0000,
        M_BIN     = 8'b0010_0000,
        M_COMMENT = 8'b0100_0000,
        M_INVALID = 8'b1000_0000
    } mode_t;

    mode_t                              mode_reg, mode_next;
    logic [ast_pkg::POS_BITS-1:0]       anchor_reg, anchor_next;
    logic [ast_pkg::POS_BITS-1:0]       pos_reg, pos_next;
    logic [ast_pkg::VAL_BITS-1:0]       acc_reg, acc_next;
    logic                               ovf_reg, ovf_next;
    logic                               dig_reg, dig_next;

    logic                               take;
    logic [7:0]                         c;
    logic                               sp;
    logic [4:0]                         base;
    logic [4:0]                         dval;
    logic                               dval_ok;
    logic [ast_pkg::ACC_EXT_BITS-1:0]   acc_ext;
    logic [ast_pkg::ACC_EXT_BITS-1:0]   acc_prod;
    logic [ast_pkg::ACC_EXT_BITS-1:0]   acc_sum;
    logic                               acc_sat;
    logic [ast_pkg::VAL_BITS-1:0]       acc_new;
    logic [ast_pkg::POS_BITS-1:0]       pos_inc;
    logic                               redo;
    logic                               cl_v, sg_v, en_v;
    ast_pkg::tok_item_t                 cl_tok, sg_tok, en_tok;

    assign take = src_valid && src_ready;
    assign src_ready = !q_full;
    assign c = src_item.char_code;
    assign sp = ast_pkg::is_space(c);
    assign pos_inc = pos_reg + 1'b1;

    // digit base of the current literal
    always_comb
    begin
        case (mode_reg)
            M_HEX:   base = 5'd16;
            M_BIN:   base = 5'd2;
            default: base = 5'd10;
        endcase
    end

    // digit value of the byte
    always_comb
    begin
        dval = 5'd16;
        if (ast_pkg::is_digit(c))
        begin
            dval = 5'(c - ast_pkg::CH_ZERO);
        end
        else if ((c >= ast_pkg::CH_LOWER_A) && (c <= ast_pkg::CH_LOWER_F))
        begin
            dval = 5'(c - ast_pkg::CH_LOWER_A + 8'd10);
        end
        else if ((c >= ast_pkg::CH_UPPER_A) && (c <= ast_pkg::CH_UPPER_F))
        begin
            dval = 5'(c - ast_pkg::CH_UPPER_A + 8'd10);
        end
    end
    assign dval_ok = dval < base;

    // acc * base + digit with saturation, by shifts and adds
    assign acc_ext = ast_pkg::ACC_EXT_BITS'(acc_reg);
    always_comb
    begin
        case (mode_reg)
            M_HEX:   acc_prod = acc_ext << 4;
            M_BIN:   acc_prod = acc_ext << 1;
            default: acc_prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
    end
    assign acc_sum = acc_prod + ast_pkg::ACC_EXT_BITS'(dval);
    assign acc_sat = |acc_sum[ast_pkg::ACC_EXT_BITS-1:ast_pkg::VAL_BITS];
    assign acc_new = acc_sat ? '1 : acc_sum[ast_pkg::VAL_BITS-1:0];

    // scan step for one byte
    always_comb
    begin
        mode_next   = mode_reg;
        anchor_next = anchor_reg;
        pos_next    = pos_inc;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        dig_next    = dig_reg;
        redo        = 1'b0;

        cl_v = 1'b0;
        cl_tok.token_kind     = ast_pkg::TK_ERROR;
        cl_tok.token_value    = '0;
        cl_tok.start_offset   = 16'(anchor_reg);
        cl_tok.token_length   = 16'(pos_reg - anchor_reg);
        cl_tok.value_overflow = 1'b0;
        cl_tok.last_of_run    = 1'b0;

        sg_v = 1'b0;
        sg_tok.token_kind     = ast_pkg::TK_NEWLINE;
        sg_tok.token_value    = '0;
        sg_tok.start_offset   = 16'(pos_reg);
        sg_tok.token_length   = 16'd1;
        sg_tok.value_overflow = 1'b0;
        sg_tok.last_of_run    = 1'b0;

        en_v = 1'b0;
        en_tok.token_kind     = ast_pkg::TK_END;
        en_tok.token_value    = '0;
        en_tok.start_offset   = 16'(pos_inc);
        en_tok.token_length   = 16'd0;
        en_tok.value_overflow = 1'b0;
        en_tok.last_of_run    = 1'b0;

        // continue or close the pending token
        case (mode_reg)
            M_IDENT:
            begin
                if (sp)
                begin
                    cl_v = 1'b1;
                    cl_tok.token_kind = ast_pkg::TK_IDENT;
                    redo = 1'b1;
                end
                else if (!((c == ast_pkg::CH_UNDER) || ast_pkg::is_alpha(c)
                           || ast_pkg::is_digit(c)))
                begin
                    mode_next = M_INVALID;
                end
            end
            M_PREFIX:
            begin
                if (c == ast_pkg::CH_DOLLAR)
                begin
                    mode_next = M_HEX;
                end
                else if (c == ast_pkg::CH_PCT)
                begin
                    mode_next = M_BIN;
                end
                else if (ast_pkg::is_digit(c))
                begin
                    mode_next = M_DEC;
                    acc_next  = acc_new;
                    ovf_next  = ovf_reg | acc_sat;
                    dig_next  = 1'b1;
                end
                else if (sp)
                begin
                    cl_v = 1'b1;
                    redo = 1'b1;
                end
                else
                begin
                    mode_next = M_INVALID;
                end
            end
            M_DEC, M_HEX, M_BIN:
            begin
                if (sp)
                begin
                    cl_v = 1'b1;
                    redo = 1'b1;
                    if (dig_reg)
                    begin
                        cl_tok.token_value    = 32'(acc_reg);
                        cl_tok.value_overflow = ovf_reg;
                        case (mode_reg)
                            M_HEX:   cl_tok.token_kind = ast_pkg::TK_HEX;
                            M_BIN:   cl_tok.token_kind = ast_pkg::TK_BINARY;
                            default: cl_tok.token_kind = ast_pkg::TK_DECIMAL;
                        endcase
                    end
                end
                else if (!dval_ok)
                begin
                    mode_next = M_INVALID;
                end
                else
                begin
                    acc_next = acc_new;
                    ovf_next = ovf_reg | acc_sat;
                    dig_next = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c == ast_pkg::CH_LF)
                begin
                    cl_v = 1'b1;
                    cl_tok.token_kind = ast_pkg::TK_COMMENT;
                    redo = 1'b1;
                end
            end
            M_INVALID:
            begin
                if (sp)
                begin
                    cl_v = 1'b1;
                    redo = 1'b1;
                end
            end
            default:
            begin
                redo = 1'b1;
            end
        endcase

        // start a new token at this byte
        if (redo)
        begin
            anchor_next = pos_reg;
            mode_next   = M_START;
            case (c)
                ast_pkg::CH_LF:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_NEWLINE;
                end
                ast_pkg::CH_LPAREN:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_LPAREN;
                end
                ast_pkg::CH_RPAREN:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_RPAREN;
                end
                ast_pkg::CH_LSQ:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_LSQUARE;
                end
                ast_pkg::CH_RSQ:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_RSQUARE;
                end
                ast_pkg::CH_COMMA:
                begin
                    sg_v = 1'b1;
                    sg_tok.token_kind = ast_pkg::TK_COMMA;
                end
                ast_pkg::CH_SEMI:
                begin
                    mode_next = M_COMMENT;
                end
                ast_pkg::CH_AT, ast_pkg::CH_DOT, ast_pkg::CH_DOLLAR:
                begin
                    mode_next = M_INVALID;
                end
                ast_pkg::CH_HASH:
                begin
                    mode_next = M_PREFIX;
                    acc_next  = '0;
                    ovf_next  = 1'b0;
                    dig_next  = 1'b0;
                end
                default:
                begin
                    if ((c == ast_pkg::CH_UNDER) || ast_pkg::is_alpha(c))
                    begin
                        mode_next = M_IDENT;
                    end
                end
            endcase
        end

        // last byte of the buffer: end token and back to reset state
        if (src_item.is_final)
        begin
            en_v        = 1'b1;
            mode_next   = M_START;
            anchor_next = '0;
            pos_next    = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
            dig_next    = 1'b0;
        end
    end

    // pack the tokens of this byte from slot 0 upward
    always_comb
    begin
        q_rec.count = ast_pkg::CNT_BITS'({1'b0, cl_v} + {1'b0, sg_v} + {1'b0, en_v});
        q_rec.slot[0] = cl_v ? cl_tok : (sg_v ? sg_tok : en_tok);
        q_rec.slot[1] = (cl_v && sg_v) ? sg_tok : en_tok;
        q_rec.slot[2] = en_tok;
    end
    assign q_push = take && (cl_v || sg_v || en_v);

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_START;
            anchor_reg <= '0;
            pos_reg    <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            dig_reg    <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            anchor_reg <= anchor_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            dig_reg    <= dig_next;
        end
    end

    // a final byte always restarts the offset count
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && src_item.is_final) |=> (pos_reg == '0) && (mode_reg == M_START))
        else $error("offset not restarted after final byte");

    // a pushed record is never empty
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_rec.count != '0))
        else $error("empty token record pushed");

    // no push while the queue is full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

endmodule

// ----- rtl/core/ast_queue.sv -----
// ast_queue: short queue of token records between scanner and output stage
// depends on ast_pkg

module ast_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ast_pkg::tok_rec_t   push_rec,
    output logic                full,
    input  logic                pop,
    output ast_pkg::q_head_t    head
);

    ast_pkg::tok_rec_t                  entry_reg [ast_pkg::QUEUE_DEPTH];
    logic [ast_pkg::QPTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ast_pkg::QPTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ast_pkg::QCNT_BITS-1:0]      cnt_reg, cnt_next;

    assign full = (cnt_reg == ast_pkg::QCNT_BITS'(ast_pkg::QUEUE_DEPTH));
    assign head.empty = (cnt_reg == '0);
    assign head.head = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg + ast_pkg::QCNT_BITS'(push) - ast_pkg::QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ast_pkg::QCNT_BITS'(ast_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ----- rtl/core/ast_back.sv -----
// ast_back: output stage that sends the tokens of each record one per cycle while tok_ready holds
// depends on ast_pkg; reads ast_queue

module ast_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ast_pkg::q_head_t    head,
    output logic                pop,
    output logic                tok_valid,
    input  logic                tok_ready,
    output ast_pkg::tok_item_t  tok_item
);

    logic                                   out_valid_reg, out_valid_next;
    ast_pkg::tok_item_t                     out_item_reg, out_item_next;
    logic [ast_pkg::SLOT_IDX_BITS-1:0]      idx_reg, idx_next;
    logic                                   load_ok;
    logic                                   slot_last;

    assign tok_valid = out_valid_reg;
    assign tok_item  = out_item_reg;
    assign load_ok   = !out_valid_reg || tok_ready;
    assign slot_last = (ast_pkg::CNT_BITS'(idx_reg) + 1'b1) == head.head.count;

    // load the next token of the head record into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = !head.empty;
            if (!head.empty)
            begin
                out_item_next = head.head.slot[idx_reg];
                out_item_next.last_of_run = slot_last;
                if (slot_last)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // a record leaves the queue only with its last token
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (tok_valid && tok_item.last_of_run))
        else $error("record popped without its last token");

    // slot index stays inside the record
    a_idx_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        !head.empty |-> (ast_pkg::CNT_BITS'(idx_reg) < head.head.count))
        else $error("slot index beyond record");

endmodule

// ----- rtl/core/assembly_source_tokenizer.sv -----
// assembly_source_tokenizer: top level, scanner, record queue and output stage
// depends on ast_pkg, ast_front, ast_queue, ast_back
//
//   channel   dir   handshake              payload
//   src       in    src_valid / src_ready  ast_pkg::src_item_t (one byte)
//   tok       out   tok_valid / tok_ready  ast_pkg::tok_item_t (one token)
//
// one byte is scanned per cycle while the queue has room; its zero to three tokens
// go to a four-record queue, and the output stage sends one token per cycle while
// tok_ready holds; a byte's first token is registered in the queue and then in the
// output register; src_ready drops only while the record queue is full
// rst_n clears scan state, queue pointers and the output valid

module assembly_source_tokenizer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  ast_pkg::src_item_t  src_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output ast_pkg::tok_item_t  tok_item
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    ast_pkg::tok_rec_t  q_rec;
    ast_pkg::q_head_t   q_head;

    ast_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (q_rec)
    );

    ast_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    ast_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

endmodule

// ----- sim/tb_assembly_source_tokenizer.sv -----
// testbench for assembly_source_tokenizer: byte stream in, token stream out
// holds its own token prediction and a scoreboard class; depends on ast_pkg and the rtl
`timescale 1ns / 100ps

// scanner modes of the predictor
typedef enum {
    SCAN_START,
    SCAN_IDENT,
    SCAN_PREFIX,
    SCAN_DEC,
    SCAN_HEX,
    SCAN_BIN,
    SCAN_COMMENT,
    SCAN_BAD
} scan_t;

// predicts the tokens of every accepted byte and matches them against the output
class token_tracker;
    scan_t                  mode;
    logic [15:0]            anchor;
    logic [15:0]            pos;
    logic [31:0]            acc;
    logic                   ovf;
    logic                   have_digit;
    ast_pkg::tok_item_t     expected_tokens[$];
    int                     mismatches;

    function new();
        reset_state();
        mismatches = 0;
    endfunction

    function void reset_state();
        mode = SCAN_START;
        anchor = '0;
        pos = '0;
        acc = '0;
        ovf = 1'b0;
        have_digit = 1'b0;
    endfunction

    function logic is_blank(logic [7:0] c);
        case (c)
            ast_pkg::CH_SPACE, ast_pkg::CH_TAB, ast_pkg::CH_LF, ast_pkg::CH_VT,
            ast_pkg::CH_FF, ast_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function logic is_letter(logic [7:0] c);
        return (c >= ast_pkg::CH_LOWER_A && c <= ast_pkg::CH_LOWER_Z)
            || (c >= ast_pkg::CH_UPPER_A && c <= ast_pkg::CH_UPPER_Z);
    endfunction

    // digit value in the given base, -1 if none
    function int digit_in_base(logic [7:0] c, int base);
        int d;
        d = -1;
        if (c >= ast_pkg::CH_ZERO && c <= ast_pkg::CH_NINE)
            d = int'(c - ast_pkg::CH_ZERO);
        else if (c >= ast_pkg::CH_LOWER_A && c <= ast_pkg::CH_LOWER_F)
            d = int'(c - ast_pkg::CH_LOWER_A) + 10;
        else if (c >= ast_pkg::CH_UPPER_A && c <= ast_pkg::CH_UPPER_F)
            d = int'(c - ast_pkg::CH_UPPER_A) + 10;
        if (d >= base)
            d = -1;
        return d;
    endfunction

    // saturating digit accumulation
    function void add_digit(int d, int base);
        logic [63:0] wide;
        logic [63:0] wbase;
        logic [63:0] wd;
        wide = {32'd0, acc};
        wbase = 64'(base);
        wd = 64'(d);
        wide = wide * wbase + wd;
        if (wide > 64'h0000_0000_FFFF_FFFF)
        begin
            acc = '1;
            ovf = 1'b1;
        end
        else
        begin
            acc = wide[31:0];
        end
        have_digit = 1'b1;
    endfunction

    function void push_token(ast_pkg::kind_t k, logic [31:0] v, logic [15:0] s,
                             logic [15:0] n, logic o);
        ast_pkg::tok_item_t t;
        t.token_kind = k;
        t.token_value = v;
        t.start_offset = s;
        t.token_length = n;
        t.value_overflow = o;
        t.last_of_run = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // one accepted byte: advance the scanner and queue its tokens
    function void note_byte(ast_pkg::src_item_t it);
        logic [7:0]     c;
        logic           reopen;
        int             d;
        int             base;
        int             first;
        ast_pkg::kind_t num_kind;
        c = it.char_code;
        reopen = 1'b0;
        first = expected_tokens.size();
        base = 10;
        num_kind = ast_pkg::TK_DECIMAL;
        case (mode)
            SCAN_IDENT:
            begin
                if (is_blank(c))
                begin
                    push_token(ast_pkg::TK_IDENT, '0, anchor, pos - anchor, 1'b0);
                    reopen = 1'b1;
                end
                else if (!(c == ast_pkg::CH_UNDER || is_letter(c) || digit_in_base(c, 10) >= 0))
                    mode = SCAN_BAD;
            end
            SCAN_PREFIX:
            begin
                if (c == ast_pkg::CH_DOLLAR)
                    mode = SCAN_HEX;
                else if (c == ast_pkg::CH_PCT)
                    mode = SCAN_BIN;
                else if (digit_in_base(c, 10) >= 0)
                begin
                    mode = SCAN_DEC;
                    add_digit(digit_in_base(c, 10), 10);
                end
                else if (is_blank(c))
                begin
                    push_token(ast_pkg::TK_ERROR, '0, anchor, pos - anchor, 1'b0);
                    reopen = 1'b1;
                end
                else
                    mode = SCAN_BAD;
            end
            SCAN_DEC, SCAN_HEX, SCAN_BIN:
            begin
                case (mode)
                    SCAN_HEX:
                    begin
                        base = 16;
                        num_kind = ast_pkg::TK_HEX;
                    end
                    SCAN_BIN:
                    begin
                        base = 2;
                        num_kind = ast_pkg::TK_BINARY;
                    end
                    default:
                    begin
                        base = 10;
                        num_kind = ast_pkg::TK_DECIMAL;
                    end
                endcase
                if (is_blank(c))
                begin
                    if (have_digit)
                        push_token(num_kind, acc, anchor, pos - anchor, ovf);
                    else
                        push_token(ast_pkg::TK_ERROR, '0, anchor, pos - anchor, 1'b0);
                    reopen = 1'b1;
                end
                else
                begin
                    d = digit_in_base(c, base);
                    if (d < 0)
                        mode = SCAN_BAD;
                    else
                        add_digit(d, base);
                end
            end
            SCAN_COMMENT:
            begin
                if (c == ast_pkg::CH_LF)
                begin
                    push_token(ast_pkg::TK_COMMENT, '0, anchor, pos - anchor, 1'b0);
                    reopen = 1'b1;
                end
            end
            SCAN_BAD:
            begin
                if (is_blank(c))
                begin
                    push_token(ast_pkg::TK_ERROR, '0, anchor, pos - anchor, 1'b0);
                    reopen = 1'b1;
                end
            end
            default: reopen = 1'b1;
        endcase

        // token start: closing bytes are looked at again from here
        if (reopen)
        begin
            anchor = pos;
            mode = SCAN_START;
            case (c)
                ast_pkg::CH_LF:     push_token(ast_pkg::TK_NEWLINE, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_LPAREN: push_token(ast_pkg::TK_LPAREN, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_RPAREN: push_token(ast_pkg::TK_RPAREN, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_LSQ:    push_token(ast_pkg::TK_LSQUARE, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_RSQ:    push_token(ast_pkg::TK_RSQUARE, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_COMMA:  push_token(ast_pkg::TK_COMMA, '0, pos, 16'd1, 1'b0);
                ast_pkg::CH_SEMI:   mode = SCAN_COMMENT;
                ast_pkg::CH_AT, ast_pkg::CH_DOT, ast_pkg::CH_DOLLAR: mode = SCAN_BAD;
                ast_pkg::CH_HASH:
                begin
                    mode = SCAN_PREFIX;
                    acc = '0;
                    ovf = 1'b0;
                    have_digit = 1'b0;
                end
                default:
                begin
                    if (c == ast_pkg::CH_UNDER || is_letter(c))
                        mode = SCAN_IDENT;
                end
            endcase
        end

        // end of buffer drops any pending token
        if (it.is_final)
        begin
            push_token(ast_pkg::TK_END, '0, pos + 16'd1, 16'd0, 1'b0);
            reset_state();
        end
        else
        begin
            pos = pos + 16'd1;
        end

        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
    endfunction

    function string tok_str(ast_pkg::tok_item_t t);
        return $sformatf("kind=%0d value=%h start=%0d len=%0d ovf=%b last=%b",
                         t.token_kind, t.token_value, t.start_offset, t.token_length,
                         t.value_overflow, t.last_of_run);
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // one accepted token against the oldest prediction
    function void check_token(ast_pkg::tok_item_t got);
        ast_pkg::tok_item_t want;
        if (expected_tokens.size() == 0)
        begin
            report({"unexpected token: ", tok_str(got)});
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind || got.token_value !== want.token_value
            || got.start_offset !== want.start_offset
            || got.token_length !== want.token_length
            || got.value_overflow !== want.value_overflow
            || got.last_of_run !== want.last_of_run)
            report({"token mismatch: expected ", tok_str(want), " actual ", tok_str(got)});
    endfunction

    function int outstanding();
        return expected_tokens.size();
    endfunction

    function void flush_leftover();
        ast_pkg::tok_item_t want;
        while (expected_tokens.size() > 0)
        begin
            want = expected_tokens.pop_front();
            report({"missing token: expected ", tok_str(want)});
        end
    endfunction
endclass

module tb_assembly_source_tokenizer;

    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 200;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    ast_pkg::src_item_t src_item = '0;
    logic               tok_valid;
    logic               tok_ready = 1'b0;
    ast_pkg::tok_item_t tok_item;

    token_tracker sb;
    bit           idle_on = 1'b0;
    int           bytes_sent = 0;
    int           idle_cycles = 0;

    assembly_source_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (src_valid && src_ready)
            begin
                sb.note_byte(src_item);
                moved = 1'b1;
            end
            if (tok_valid && tok_ready)
            begin
                sb.check_token(tok_item);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // output back-pressure in random bursts
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                tok_ready <= 1'b0;
            else if (hold > 0)
            begin
                hold--;
                tok_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 7);
                tok_ready <= 1'b0;
            end
            else
                tok_ready <= 1'b1;
        end
    end

    // drive one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] c, input logic fin);
        int                 gap;
        ast_pkg::src_item_t it;
        it.char_code = c;
        it.is_final = fin;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item <= it;
        @(posedge clk);
        while (!src_ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit final_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], final_last && (i == s.len() - 1));
    endtask

    // random byte with an occasional end of buffer
    task automatic put_byte(input logic [7:0] c);
        send_byte(c, $urandom_range(0, 59) == 0);
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0: return ast_pkg::CH_TAB;
            1: return ast_pkg::CH_LF;
            2: return ast_pkg::CH_VT;
            3: return ast_pkg::CH_FF;
            4: return ast_pkg::CH_CR;
            default: return ast_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 25);
        if ($urandom_range(0, 1))
            return 8'(ast_pkg::CH_LOWER_A + r);
        return 8'(ast_pkg::CH_UPPER_A + r);
    endfunction

    function automatic logic [7:0] rand_hex_digit();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
            return 8'(ast_pkg::CH_ZERO + r);
        if ($urandom_range(0, 1))
            return 8'(ast_pkg::CH_LOWER_A + r - 10);
        return 8'(ast_pkg::CH_UPPER_A + r - 10);
    endfunction

    // one mostly well-formed token with random content, sometimes noise
    task automatic send_random_token();
        int         pick;
        int         n;
        logic [7:0] r;
        pick = $urandom_range(0, 11);
        case (pick)
            0, 10:
            begin
                case ($urandom_range(0, 4))
                    0: put_byte(ast_pkg::CH_LPAREN);
                    1: put_byte(ast_pkg::CH_RPAREN);
                    2: put_byte(ast_pkg::CH_LSQ);
                    3: put_byte(ast_pkg::CH_RSQ);
                    default: put_byte(ast_pkg::CH_COMMA);
                endcase
            end
            1, 2:
            begin
                put_byte(($urandom_range(0, 5) == 0) ? ast_pkg::CH_UNDER : rand_letter());
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 2))
                        0: put_byte(rand_letter());
                        1: put_byte(8'(ast_pkg::CH_ZERO + $urandom_range(0, 9)));
                        default: put_byte(ast_pkg::CH_UNDER);
                    endcase
                end
                put_byte(rand_blank());
            end
            3:
            begin
                put_byte(ast_pkg::CH_HASH);
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
                repeat (n) put_byte(8'(ast_pkg::CH_ZERO + $urandom_range(0, 9)));
                put_byte(rand_blank());
            end
            4:
            begin
                put_byte(ast_pkg::CH_HASH);
                put_byte(ast_pkg::CH_DOLLAR);
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 4);
                repeat (n) put_byte(rand_hex_digit());
                put_byte(rand_blank());
            end
            5:
            begin
                put_byte(ast_pkg::CH_HASH);
                put_byte(ast_pkg::CH_PCT);
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(31, 35) : $urandom_range(0, 6);
                repeat (n) put_byte(8'(ast_pkg::CH_ZERO + $urandom_range(0, 1)));
                put_byte(rand_blank());
            end
            6:
            begin
                put_byte(ast_pkg::CH_SEMI);
                repeat ($urandom_range(0, 6))
                begin
                    r = 8'($urandom_range(0, 255));
                    put_byte((r == ast_pkg::CH_LF) ? ast_pkg::CH_SPACE : r);
                end
                put_byte(ast_pkg::CH_LF);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: put_byte(ast_pkg::CH_AT);
                    1: put_byte(ast_pkg::CH_DOT);
                    default: put_byte(ast_pkg::CH_DOLLAR);
                endcase
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
                put_byte(rand_blank());
            end
            8:
            begin
                // token broken by a stray byte
                put_byte($urandom_range(0, 1) ? ast_pkg::CH_HASH : rand_letter());
                put_byte(8'($urandom_range(0, 255)));
                put_byte(rand_blank());
            end
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // stimulus and end of run
    initial
    begin
        int n;
        int start_count;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every token kind, skipped bytes, broken prefixes, end of buffer
        idle_on = 1'b1;
        send_text("()[],a_ #9\t#$F\015#%1\013# #% $", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ast_pkg::CH_LF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(";@\n.", 1'b1);

        // random token stream, idling in stretches, none at the tail
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS)
        begin
            n = bytes_sent - start_count;
            idle_on = (n < RANDOM_ITEMS - 40) && ((n / 60) % 3 != 2);
            send_random_token();
        end
        idle_on = 1'b0;
        src_valid <= 1'b0;

        // drain
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        sb.flush_leftover();
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
